// ----- rtl/sfb_pkg.sv -----
// Shared types and constants of the serial frame builder.
// Used by the front, queue, back and top level; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package sfb_pkg;

  localparam int unsigned MAX_PAYLOAD_DEF = 1024;

  localparam int unsigned LEN_W  = 11;
  localparam int unsigned SEQ_W  = 8;
  localparam int unsigned CMD_W  = 16;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam int unsigned QUEUE_DEPTH = 2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PAYLOAD_LENGTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SEQUENCE_BYTE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COMMAND_ID     = 2'd2;

  localparam logic [LEN_W-1:0] LEN_RESET = 11'd1;
  localparam logic [SEQ_W-1:0] SEQ_RESET = 8'h00;
  localparam logic [CMD_W-1:0] CMD_RESET = 16'h000F;

  localparam logic [7:0]  START_BYTE      = 8'hA5;
  localparam logic [7:0]  CRC8_SEED       = 8'hFF;
  localparam logic [7:0]  CRC8_POLY_REFL  = 8'h8C;
  localparam logic [15:0] CRC16_SEED      = 16'hFFFF;
  localparam logic [15:0] CRC16_POLY_REFL = 16'h8408;

  // byte slots within one item's output sequence
  typedef logic [3:0] step_t;
  localparam step_t STEP_START   = 4'd0;
  localparam step_t STEP_LEN_LO  = 4'd1;
  localparam step_t STEP_LEN_HI  = 4'd2;
  localparam step_t STEP_SEQ     = 4'd3;
  localparam step_t STEP_CRC8    = 4'd4;
  localparam step_t STEP_CMD_LO  = 4'd5;
  localparam step_t STEP_CMD_HI  = 4'd6;
  localparam step_t STEP_DATA    = 4'd7;
  localparam step_t STEP_CRC_LO  = 4'd8;
  localparam step_t STEP_CRC_HI  = 4'd9;

  typedef struct packed {
    logic              first;
    logic              last;
    logic [LEN_W-1:0]  len;
    logic [SEQ_W-1:0]  seq;
    logic [CMD_W-1:0]  cmd;
    logic [BYTE_W-1:0] data;
  } sfb_item_t;

  typedef struct packed {
    logic valid;
    logic pop;
  } sfb_qctl_t;

endpackage

`default_nettype wire

// ----- rtl/sfb_front.sv -----
// Front end: configuration registers, frame position tracking and item classification.
// Depends on sfb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sfb_front
  import sfb_pkg::*;
#(
  parameter int unsigned MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [BYTE_W-1:0]     in_payload_byte,
  input  wire logic                  q_full,
  output logic                       q_push,
  output sfb_item_t                  q_item
);

  localparam int unsigned CLOG_W = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
  localparam int unsigned POS_W  = (CLOG_W > LEN_W) ? LEN_W : CLOG_W;
  localparam int unsigned CMP_W  = ((POS_W > LEN_W) ? POS_W : LEN_W) + 1;

  logic [LEN_W-1:0] len_r;
  logic [SEQ_W-1:0] seq_r;
  logic [CMD_W-1:0] cmd_r;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [LEN_W-1:0] len_eff;
  logic [CMP_W-1:0] pos_inc;
  logic             is_last;

  assign cfg_ready = 1'b1;
  assign in_stall  = q_full;
  assign q_push    = in_valid && !q_full;

  always_comb begin
    if (len_r == '0) begin
      len_eff = LEN_W'(1);
    end else if (32'(len_r) > 32'(MAX_PAYLOAD)) begin
      len_eff = LEN_W'(MAX_PAYLOAD);
    end else begin
      len_eff = len_r;
    end
    pos_inc = CMP_W'(pos_r) + CMP_W'(1);
    is_last = pos_inc >= CMP_W'(len_eff);
    pos_nxt = is_last ? '0 : POS_W'(pos_inc);
  end

  always_comb begin
    q_item.first = (pos_r == '0);
    q_item.last  = is_last;
    q_item.len   = len_eff;
    q_item.seq   = seq_r;
    q_item.cmd   = cmd_r;
    q_item.data  = in_payload_byte;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= LEN_RESET;
      seq_r <= SEQ_RESET;
      cmd_r <= CMD_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_PAYLOAD_LENGTH: len_r <= cfg_data[LEN_W-1:0];
        CFG_SEQUENCE_BYTE:  seq_r <= cfg_data[SEQ_W-1:0];
        CFG_COMMAND_ID:     cmd_r <= cfg_data[CMD_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else if (q_push) begin
      pos_r <= pos_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/sfb_queue.sv -----
// Short item queue between the front and the back.
// Depends on sfb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sfb_queue
  import sfb_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      push,
  input  wire sfb_item_t push_item,
  output logic           full,
  input  wire sfb_qctl_t ctl_in,
  output logic           head_valid,
  output sfb_item_t      head_item,
  output logic [$clog2(QUEUE_DEPTH+1)-1:0] count
);

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  sfb_item_t        mem [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_pop;

  assign full       = (count_r == CNT_W'(QUEUE_DEPTH));
  assign head_valid = (count_r != '0);
  assign head_item  = mem[rd_ptr_r];
  assign count      = count_r;
  assign do_pop     = ctl_in.pop && head_valid;

  always_comb begin
    count_nxt = count_r;
    if (push && !do_pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_pop && !push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (32'(wr_ptr_r) == QUEUE_DEPTH - 1) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (32'(rd_ptr_r) == QUEUE_DEPTH - 1) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      count_r <= count_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/sfb_back.sv -----
// Back end: byte sequencer, header CRC-8, frame CRC-16 and output register.
// Depends on sfb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sfb_back
  import sfb_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               head_valid,
  input  wire sfb_item_t          head_item,
  output sfb_qctl_t               ctl_out,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [BYTE_W-1:0]       out_frame_byte,
  output logic                    out_frame_end
);

  function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC8_POLY_REFL) : (c >> 1);
    end
    return c;
  endfunction

  function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC16_POLY_REFL) : (c >> 1);
    end
    return c;
  endfunction

  logic              active_r, active_nxt;
  step_t             step_r, step_nxt;
  logic [7:0]        crc8_r, crc8_nxt;
  logic [15:0]       crc16_r, crc16_nxt;
  logic              out_valid_r;
  logic [BYTE_W-1:0] out_byte_r;
  logic              out_end_r;

  step_t             cur_step;
  step_t             last_step;
  logic              emit;
  logic              done;
  logic [7:0]        cur_byte;
  logic [15:0]       len_ext;

  assign out_valid      = out_valid_r;
  assign out_frame_byte = out_byte_r;
  assign out_frame_end  = out_end_r;

  always_comb begin
    len_ext   = {{(16 - LEN_W){1'b0}}, head_item.len};
    cur_step  = active_r ? step_r : (head_item.first ? STEP_START : STEP_DATA);
    last_step = head_item.last ? STEP_CRC_HI : STEP_DATA;
    emit      = head_valid && (!out_valid_r || !out_stall);
    done      = emit && (cur_step == last_step);

    unique case (cur_step)
      STEP_START:  cur_byte = START_BYTE;
      STEP_LEN_LO: cur_byte = len_ext[7:0];
      STEP_LEN_HI: cur_byte = len_ext[15:8];
      STEP_SEQ:    cur_byte = head_item.seq;
      STEP_CRC8:   cur_byte = crc8_r;
      STEP_CMD_LO: cur_byte = head_item.cmd[7:0];
      STEP_CMD_HI: cur_byte = head_item.cmd[15:8];
      STEP_DATA:   cur_byte = head_item.data;
      STEP_CRC_LO: cur_byte = crc16_r[7:0];
      STEP_CRC_HI: cur_byte = crc16_r[15:8];
      default:     cur_byte = 8'h00;
    endcase

    crc8_nxt = crc8_r;
    if (emit && (cur_step <= STEP_SEQ)) begin
      crc8_nxt = crc8_step((cur_step == STEP_START) ? CRC8_SEED : crc8_r, cur_byte);
    end
    crc16_nxt = crc16_r;
    if (emit && (cur_step <= STEP_DATA)) begin
      crc16_nxt = crc16_step((cur_step == STEP_START) ? CRC16_SEED : crc16_r, cur_byte);
    end

    active_nxt = active_r;
    step_nxt   = step_r;
    if (emit) begin
      active_nxt = !done;
      step_nxt   = cur_step + step_t'(1);
    end

    ctl_out.valid = head_valid;
    ctl_out.pop   = done;
  end

  always_ff @(posedge clk) begin
    crc8_r  <= crc8_nxt;
    crc16_r <= crc16_nxt;
    step_r  <= step_nxt;
    if (emit) begin
      out_byte_r <= cur_byte;
      out_end_r  <= (cur_step == STEP_CRC_HI);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      active_r <= active_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/serial_frame_builder_crc8_crc16_top.sv -----
// Top level of the serial frame builder with CRC-8 header and CRC-16 trailer.
// Depends on sfb_pkg, sfb_front, sfb_queue and sfb_back.
//
// Usage:
//   in_*   : one payload byte per transfer (valid/stall).
//   out_*  : one frame byte per transfer (valid/stall); out_frame_end marks
//            the high CRC-16 byte that closes a frame.
//   cfg_*  : register writes (valid/ready, always ready): index 0 payload
//            length, 1 sequence byte, 2 command id. Write only while idle.
// Each payload byte yields one output byte; the first byte of a frame adds
// seven header bytes and the last byte two CRC bytes, so an item yields
// 1 to 10 output bytes, sent at one byte per cycle while the output is not stalled.
// An accepted byte is first written into the queue; its first output byte is
// then loaded into the output register, where an output stall holds it.
// A two-entry queue separates input from output, so input is taken while
// earlier items are still being sent.
// Reset clears the queue, the frame position and the output valid flag and
// restores register defaults. A stall on the output holds the current byte
// and the back end; the front keeps taking input until the queue fills.
`timescale 1ns / 1ps
`default_nettype none

module serial_frame_builder_crc8_crc16_top
  import sfb_pkg::*;
#(
  parameter int unsigned MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [BYTE_W-1:0]     in_payload_byte,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [BYTE_W-1:0]          out_frame_byte,
  output logic                       out_frame_end
);

  sfb_item_t push_item;
  sfb_item_t head_item;
  sfb_qctl_t qctl;
  logic      q_push;
  logic      q_full;
  logic      head_valid;
  logic [$clog2(QUEUE_DEPTH+1)-1:0] q_count;

  sfb_front #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_payload_byte(in_payload_byte),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_item         (push_item)
  );

  sfb_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (push_item),
    .full      (q_full),
    .ctl_in    (qctl),
    .head_valid(head_valid),
    .head_item (head_item),
    .count     (q_count)
  );

  sfb_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .head_valid    (head_valid),
    .head_item     (head_item),
    .ctl_out       (qctl),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_frame_byte(out_frame_byte),
    .out_frame_end (out_frame_end)
  );

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid && !in_stall)
    else $error("outputs not idle after reset");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(q_count) <= QUEUE_DEPTH)
    else $error("queue count beyond depth");

  a_pop_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    qctl.pop |-> qctl.valid)
    else $error("queue popped while empty");

  a_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    (q_full && !qctl.pop) |=> q_count == $past(q_count))
    else $error("queue written while full");

endmodule

`default_nettype wire
